// ===== hdl/i2cm_pkg.sv =====
`timescale 1ns / 1ps

package i2cm_pkg;

	// Input item kinds.
	localparam logic [1:0] KIND_TICK        = 2'd0;
	localparam logic [1:0] KIND_BEGIN_READ  = 2'd1;
	localparam logic [1:0] KIND_BEGIN_WRITE = 2'd2;
	localparam logic [1:0] KIND_SUPPLY      = 2'd3;

	// Completion status codes.
	localparam logic [1:0] STATUS_OK         = 2'd0;
	localparam logic [1:0] STATUS_ADDR_NACK  = 2'd1;
	localparam logic [1:0] STATUS_DATA_NACK  = 2'd2;

	// Configuration register indexes and reset values.
	localparam int unsigned CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_ACK_POLL_LIMIT   = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ADDR_ATTEMPT_LIM = 2'd1;
	localparam logic [15:0] ACK_POLL_LIMIT_RST   = 16'd2000;
	localparam logic [15:0] ADDR_ATTEMPT_LIM_RST = 16'd500;

	// One result item.
	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       sda_driven;
		logic       byte_request;
		logic       read_valid;
		logic [7:0] read_data;
		logic       busy_res;
		logic       done_res;
		logic [1:0] status;
	} result_t;

endpackage

// ===== hdl/i2cm_core.sv =====
`timescale 1ns / 1ps

module i2cm_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [1:0]         kind,
	input  logic [7:0]         address_byte,
	input  logic [7:0]         transfer_length,
	input  logic [7:0]         write_byte,
	input  logic               sda_sample,
	input  logic [15:0]        ack_poll_limit,
	input  logic [15:0]        address_attempt_limit,
	output i2cm_pkg::result_t  res
);
	import i2cm_pkg::*;

	typedef enum logic [3:0] {
		PH_IDLE, PH_START, PH_TXA, PH_TXD, PH_ACKA, PH_ACKD,
		PH_LOAD, PH_RX, PH_RXACK, PH_PRESTOP, PH_STOP
	} phase_t;

	phase_t      phase_q, n_phase;
	logic [2:0]  unit_q, n_unit;
	logic [3:0]  bit_q, n_bit, bit_inc;
	logic [7:0]  shift_q, n_shift, rx_shift;
	logic [7:0]  bytes_q, n_bytes;
	logic [15:0] att_q, n_att;
	logic [15:0] poll_q, n_poll, poll_inc;
	logic [7:0]  hold_q, n_hold;
	logic        hold_full_q, n_hold_full;
	logic        is_read_q, n_is_read;
	logic [7:0]  addr_q, n_addr;
	logic        scl_q, n_scl, sda_q, n_sda, drv_q, n_drv;
	logic        rv, done, acked, wants_now, wants_next;
	logic [7:0]  rd;
	logic [1:0]  st;
	logic [15:0] poll_lim, att_lim;

	assign poll_lim = (ack_poll_limit == 16'd0) ? 16'd1 : ack_poll_limit;
	assign att_lim  = (address_attempt_limit == 16'd0) ? 16'd1 : address_attempt_limit;
	assign bit_inc  = 4'(bit_q + 4'd1);
	assign poll_inc = 16'(poll_q + 16'd1);
	assign rx_shift = {shift_q[6:0], sda_sample};
	assign acked    = ~sda_sample;
	assign wants_now = (phase_q != PH_IDLE) && !is_read_q && (bytes_q != 8'd0) && !hold_full_q;

	always_comb begin
		n_phase = phase_q; n_unit = unit_q; n_bit = bit_q; n_shift = shift_q;
		n_bytes = bytes_q; n_att = att_q; n_poll = poll_q; n_hold = hold_q;
		n_hold_full = hold_full_q; n_is_read = is_read_q; n_addr = addr_q;
		n_scl = scl_q; n_sda = sda_q; n_drv = drv_q;
		rv = 1'b0; rd = 8'd0; done = 1'b0; st = STATUS_OK;
		unique case (kind)
			KIND_BEGIN_READ, KIND_BEGIN_WRITE: begin
				if (phase_q == PH_IDLE) begin
					n_addr = address_byte;
					n_is_read = (kind == KIND_BEGIN_READ);
					n_bytes = (n_is_read && transfer_length == 8'd0) ? 8'd1 : transfer_length;
					n_att = att_lim;
					n_hold_full = 1'b0; n_unit = 3'd0; n_bit = 4'd0; n_poll = 16'd0;
					n_phase = PH_START;
				end
			end
			KIND_SUPPLY: begin
				if (wants_now) begin
					n_hold = write_byte;
					n_hold_full = 1'b1;
				end
			end
			default: begin
				unique case (phase_q)
					PH_START: begin
						n_drv = 1'b1; n_scl = 1'b1;
						n_sda = (unit_q == 3'd0);
						if (unit_q == 3'd0) begin
							n_unit = 3'd1;
						end else begin
							n_unit = 3'd0; n_bit = 4'd0; n_shift = addr_q; n_phase = PH_TXA;
						end
					end
					PH_TXA, PH_TXD: begin
						n_drv = 1'b1;
						n_scl = (unit_q >= 3'd2);
						if (unit_q == 3'd1) n_sda = shift_q[7];
						if (unit_q < 3'd3) begin
							n_unit = 3'(unit_q + 3'd1);
						end else begin
							n_unit = 3'd0;
							n_shift = {shift_q[6:0], 1'b0};
							n_bit = bit_inc;
							if (bit_inc >= 4'd8) begin
								n_bit = 4'd0;
								n_phase = (phase_q == PH_TXA) ? PH_ACKA : PH_ACKD;
							end
						end
					end
					PH_ACKA, PH_ACKD: begin
						n_drv = 1'b0;
						n_scl = (unit_q >= 3'd2);
						if (unit_q < 3'd4) begin
							n_unit = 3'(unit_q + 3'd1);
							if (unit_q == 3'd3) n_poll = 16'd0;
						end else if (!acked && poll_inc < poll_lim) begin
							n_poll = poll_inc;
						end else begin
							if (!acked) n_poll = poll_inc;
							n_unit = 3'd0; n_bit = 4'd0;
							if (phase_q == PH_ACKA) begin
								if (acked) begin
									if (is_read_q) begin
										n_shift = 8'd0; n_phase = PH_RX;
									end else begin
										n_phase = (bytes_q != 8'd0) ? PH_LOAD : PH_PRESTOP;
									end
								end else begin
									n_att = 16'(att_q - 16'd1);
									if (n_att == 16'd0) begin
										n_phase = PH_IDLE; done = 1'b1; st = STATUS_ADDR_NACK;
									end else begin
										n_phase = PH_START;
									end
								end
							end else begin
								if (acked) begin
									n_phase = (bytes_q != 8'd0) ? PH_LOAD : PH_PRESTOP;
								end else begin
									n_phase = PH_IDLE; done = 1'b1; st = STATUS_DATA_NACK;
								end
							end
						end
					end
					PH_LOAD: begin
						n_drv = 1'b0; n_scl = 1'b0;
						if (hold_full_q) begin
							// The first tick of the first bit runs on this same tick.
							n_shift = hold_q; n_hold_full = 1'b0;
							n_bytes = 8'(bytes_q - 8'd1);
							n_bit = 4'd0; n_unit = 3'd1; n_phase = PH_TXD;
							n_drv = 1'b1;
						end
					end
					PH_RX: begin
						n_drv = 1'b0;
						n_scl = (unit_q >= 3'd3);
						if (unit_q < 3'd4) begin
							n_unit = 3'(unit_q + 3'd1);
						end else begin
							n_unit = 3'd0;
							n_shift = rx_shift;
							n_bit = bit_inc;
							if (bit_inc >= 4'd8) begin
								n_bit = 4'd0;
								rv = 1'b1; rd = rx_shift;
								if (bytes_q != 8'd0) n_bytes = 8'(bytes_q - 8'd1);
								n_phase = PH_RXACK;
							end
						end
					end
					PH_RXACK: begin
						n_drv = 1'b1;
						n_scl = (unit_q >= 3'd2);
						if (unit_q == 3'd1) n_sda = (bytes_q == 8'd0);
						if (unit_q < 3'd3) begin
							n_unit = 3'(unit_q + 3'd1);
						end else begin
							n_unit = 3'd0;
							n_phase = (bytes_q != 8'd0) ? PH_RX : PH_STOP;
						end
					end
					PH_PRESTOP: begin
						n_drv = 1'b0; n_scl = 1'b0;
						if (unit_q < 3'd1) begin
							n_unit = 3'(unit_q + 3'd1);
						end else begin
							n_unit = 3'd0; n_phase = PH_STOP;
						end
					end
					PH_STOP: begin
						n_drv = 1'b1; n_scl = 1'b1;
						n_sda = (unit_q != 3'd0);
						if (unit_q == 3'd0) begin
							n_unit = 3'd1;
						end else begin
							n_unit = 3'd0; n_phase = PH_IDLE; done = 1'b1; st = STATUS_OK;
						end
					end
					PH_IDLE: begin
					end
					default: begin
						n_phase = PH_IDLE; n_unit = 3'd0;
					end
				endcase
			end
		endcase
	end

	assign wants_next = (n_phase != PH_IDLE) && !n_is_read && (n_bytes != 8'd0) && !n_hold_full;

	always_comb begin
		res.scl_level    = n_scl;
		res.sda_level    = n_sda;
		res.sda_driven   = n_drv;
		res.byte_request = wants_next;
		res.read_valid   = rv;
		res.read_data    = rd;
		res.busy_res     = (n_phase != PH_IDLE);
		res.done_res     = done;
		res.status       = done ? st : STATUS_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE; unit_q <= 3'd0; bit_q <= 4'd0; shift_q <= 8'd0;
			bytes_q <= 8'd0; att_q <= 16'd0; poll_q <= 16'd0; hold_q <= 8'd0;
			hold_full_q <= 1'b0; is_read_q <= 1'b0; addr_q <= 8'd0;
			scl_q <= 1'b1; sda_q <= 1'b1; drv_q <= 1'b1;
		end else if (accept) begin
			phase_q <= n_phase; unit_q <= n_unit; bit_q <= n_bit; shift_q <= n_shift;
			bytes_q <= n_bytes; att_q <= n_att; poll_q <= n_poll; hold_q <= n_hold;
			hold_full_q <= n_hold_full; is_read_q <= n_is_read; addr_q <= n_addr;
			sda_q <= n_sda;
			// After a failed transaction the clock is parked low and SDA released.
			scl_q <= (done && st != STATUS_OK) ? 1'b0 : n_scl;
			drv_q <= (done && st != STATUS_OK) ? 1'b0 : n_drv;
		end
	end

endmodule

// ===== hdl/i2cm_out_reg.sv =====
`timescale 1ns / 1ps

module i2cm_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  i2cm_pkg::result_t  d,
	output logic               out_valid,
	input  logic               out_stall,
	output i2cm_pkg::result_t  q
);
	import i2cm_pkg::*;

	logic    valid_q;
	result_t data_q;

	// The slot can refill in the same cycle that the consumer takes it.
	assign in_stall  = valid_q & out_stall;
	assign out_valid = valid_q;
	assign q         = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_q <= d;
		end
	end

endmodule

// ===== hdl/i2c_master_bit_engine_unit.sv =====
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// input     in_valid / in_stall    kind, address_byte, transfer_length, write_byte, sda_sample
// output    out_valid / out_stall  scl_level, sda_level, sda_driven, byte_request, read_valid,
//                                  read_data, busy_res, done_res, status
// config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Every accepted input transaction yields exactly one output transaction. The bus
// sequencer advances its state in the cycle the item is taken, and the result lands
// in a single output register, so one item per clock is sustained unless the consumer stalls.
// The input is stalled only when the output register is full and the consumer stalls.
// Reset puts the sequencer in idle with SCL, SDA and the SDA drive enable all high,
// the output register empty, and the limits at 2000 polls and 500 attempts.
// Configuration writes are always ready; indexes beyond the two registers are ignored.

module i2c_master_bit_engine_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           kind,
	input  logic [7:0]                           address_byte,
	input  logic [7:0]                           transfer_length,
	input  logic [7:0]                           write_byte,
	input  logic                                 sda_sample,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 scl_level,
	output logic                                 sda_level,
	output logic                                 sda_driven,
	output logic                                 byte_request,
	output logic                                 read_valid,
	output logic [7:0]                           read_data,
	output logic                                 busy_res,
	output logic                                 done_res,
	output logic [1:0]                           status,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [i2cm_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [15:0]                          cfg_data
);
	import i2cm_pkg::*;

	logic [15:0] ack_poll_limit_q;
	logic [15:0] address_attempt_limit_q;
	logic        accept;
	result_t     step_res;
	result_t     out_res;

	// The configuration port never backs up.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_poll_limit_q        <= ACK_POLL_LIMIT_RST;
			address_attempt_limit_q <= ADDR_ATTEMPT_LIM_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_ACK_POLL_LIMIT) ack_poll_limit_q <= cfg_data;
			if (cfg_index == CFG_ADDR_ATTEMPT_LIM) address_attempt_limit_q <= cfg_data;
		end
	end

	// The sequencer state moves only when an input transaction is taken.
	assign accept = in_valid & ~in_stall;

	i2cm_core u_core (
		.clk                   (clk),
		.arst_n                (arst_n),
		.accept                (accept),
		.kind                  (kind),
		.address_byte          (address_byte),
		.transfer_length       (transfer_length),
		.write_byte            (write_byte),
		.sda_sample            (sda_sample),
		.ack_poll_limit        (ack_poll_limit_q),
		.address_attempt_limit (address_attempt_limit_q),
		.res                   (step_res)
	);

	i2cm_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.d         (step_res),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.q         (out_res)
	);

	assign scl_level    = out_res.scl_level;
	assign sda_level    = out_res.sda_level;
	assign sda_driven   = out_res.sda_driven;
	assign byte_request = out_res.byte_request;
	assign read_valid   = out_res.read_valid;
	assign read_data    = out_res.read_data;
	assign busy_res     = out_res.busy_res;
	assign done_res     = out_res.done_res;
	assign status       = out_res.status;

endmodule

// ===== hdl/i2cm_checker.sv =====
`timescale 1ns / 1ps

module i2cm_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       scl_level,
	input logic       sda_level,
	input logic       sda_driven,
	input logic       byte_request,
	input logic       read_valid,
	input logic [7:0] read_data,
	input logic       busy_res,
	input logic       done_res,
	input logic [1:0] status
);
	import i2cm_pkg::*;

	// A stalled result holds until it is taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_data) && $stable(status)
			&& $stable(done_res) && $stable(busy_res) && $stable(scl_level)
			&& $stable(sda_level) && $stable(sda_driven) && $stable(byte_request)
			&& $stable(read_valid))
		else $error("result changed while stalled");

	// Status is only reported together with the end of a transaction.
	a_status_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !done_res |-> status == STATUS_OK)
		else $error("status without done");

	// Received data is zero unless a byte completed.
	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !read_valid |-> read_data == 8'd0)
		else $error("read data without read valid");

	// The end of a transaction leaves the engine idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res && !byte_request)
		else $error("busy after done");

	// A byte can only be requested during a transaction.
	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_request |-> busy_res && !read_valid)
		else $error("byte request while idle");

endmodule

bind i2c_master_bit_engine_unit i2cm_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.scl_level    (scl_level),
	.sda_level    (sda_level),
	.sda_driven   (sda_driven),
	.byte_request (byte_request),
	.read_valid   (read_valid),
	.read_data    (read_data),
	.busy_res     (busy_res),
	.done_res     (done_res),
	.status       (status)
);

// ===== dv/tb_i2c_master_bit_engine_unit.sv =====
`timescale 1ns / 1ps

module tb_i2c_master_bit_engine_unit;
	import i2cm_pkg::*;

	// Sequencer phases of the bus engine, as this bench tracks them.
	localparam logic [4:0] PH_IDLE     = 5'd0;
	localparam logic [4:0] PH_START    = 5'd1;
	localparam logic [4:0] PH_ADDR_TX  = 5'd2;
	localparam logic [4:0] PH_DATA_TX  = 5'd3;
	localparam logic [4:0] PH_ADDR_ACK = 5'd4;
	localparam logic [4:0] PH_DATA_ACK = 5'd5;
	localparam logic [4:0] PH_LOAD     = 5'd6;
	localparam logic [4:0] PH_RX       = 5'd7;
	localparam logic [4:0] PH_RX_ACK   = 5'd8;
	localparam logic [4:0] PH_PRESTOP  = 5'd9;
	localparam logic [4:0] PH_STOP     = 5'd10;

	// Cycles without any accepted transaction on any channel before the run is abandoned.
	localparam int QUIET_LIMIT = 4000;
	localparam int REPORT_LIMIT = 10;

	// Full sequencer state, kept twice: once as seen by the stimulus planner, which runs
	// ahead in zero time, and once as seen by the checker, which advances on acceptance.
	typedef struct packed {
		logic [4:0]  phase;
		logic [2:0]  unit_cnt;
		logic [3:0]  bit_idx;
		logic [7:0]  shifter;
		logic [7:0]  bytes_left;
		logic [15:0] attempts_left;
		logic [15:0] polls;
		logic [7:0]  hold_byte;
		logic        hold_full;
		logic        rd_mode;
		logic [7:0]  addr;
		logic        scl;
		logic        sda;
		logic        drive;
	} bus_engine_t;

	// One input transaction.
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] addr;
		logic [7:0] len;
		logic [7:0] wbyte;
		logic       sda;
	} bus_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                   in_valid = 1'b0;
	logic                   in_stall;
	logic [1:0]             kind = KIND_TICK;
	logic [7:0]             address_byte = 8'd0;
	logic [7:0]             transfer_length = 8'd0;
	logic [7:0]             write_byte = 8'd0;
	logic                   sda_sample = 1'b0;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic                   scl_level;
	logic                   sda_level;
	logic                   sda_driven;
	logic                   byte_request;
	logic                   read_valid;
	logic [7:0]             read_data;
	logic                   busy_res;
	logic                   done_res;
	logic [1:0]             status;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = CFG_ACK_POLL_LIMIT;
	logic [15:0]            cfg_data = 16'd0;

	bus_item_t   pending_bus_items[$];
	result_t     predicted_bus_q[$];
	bus_engine_t planned_bus;
	bus_engine_t accepted_bus;
	logic [15:0] ack_poll_limit_cfg = ACK_POLL_LIMIT_RST;
	logic [15:0] attempt_limit_cfg = ADDR_ATTEMPT_LIM_RST;
	int          planned_count = 0;
	int          gap_pct = 15;
	int          fault_count = 0;
	int          results_seen = 0;
	int          quiet_cycles = 0;
	logic        verdict_given = 1'b0;

	i2c_master_bit_engine_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.address_byte(address_byte),
		.transfer_length(transfer_length),
		.write_byte(write_byte),
		.sda_sample(sda_sample),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.scl_level(scl_level),
		.sda_level(sda_level),
		.sda_driven(sda_driven),
		.byte_request(byte_request),
		.read_valid(read_valid),
		.read_data(read_data),
		.busy_res(busy_res),
		.done_res(done_res),
		.status(status),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// ------------------------------------------------------------------------------------
	// Bus engine prediction
	// ------------------------------------------------------------------------------------

	function automatic bus_engine_t bus_after_reset();
		bus_engine_t s;
		s = '0;
		s.phase = PH_IDLE;
		// The bus idles with both lines high and the master driving SDA.
		s.scl = 1'b1;
		s.sda = 1'b1;
		s.drive = 1'b1;
		return s;
	endfunction

	function automatic logic [15:0] at_least_one(input logic [15:0] v);
		return (v == 16'd0) ? 16'd1 : v;
	endfunction

	// A write byte is wanted while a write is running, bytes remain and the holder is empty.
	function automatic logic bus_wants_byte(input bus_engine_t s);
		return s.phase != PH_IDLE && !s.rd_mode && s.bytes_left != 8'd0 && !s.hold_full;
	endfunction

	// One tick of a transmitted bit: SCL low twice (the bit is set up on the second), then
	// SCL high twice. After eight bits the acknowledge slot follows.
	function automatic void shift_out_tick(inout bus_engine_t s);
		s.drive = 1'b1;
		s.scl = (s.unit_cnt >= 3'd2);
		if (s.unit_cnt == 3'd1)
			s.sda = s.shifter[7];
		if (s.unit_cnt < 3'd3) begin
			s.unit_cnt = s.unit_cnt + 3'd1;
		end else begin
			s.unit_cnt = 3'd0;
			s.shifter = {s.shifter[6:0], 1'b0};
			s.bit_idx = s.bit_idx + 4'd1;
			if (s.bit_idx >= 4'd8) begin
				s.bit_idx = 4'd0;
				s.phase = (s.phase == PH_ADDR_TX) ? PH_ADDR_ACK : PH_DATA_ACK;
			end
		end
	endfunction

	// Advances the engine by one input transaction and returns the result it produces.
	function automatic result_t advance_bus_engine(inout bus_engine_t s, input bus_item_t it,
			input logic [15:0] poll_lim, input logic [15:0] attempt_lim);
		result_t    r;
		logic       acked;
		logic       still_polling;
		logic       ended;
		logic [1:0] code;
		r = '0;
		ended = 1'b0;
		code = STATUS_OK;
		still_polling = 1'b0;
		case (it.kind)
			KIND_BEGIN_READ, KIND_BEGIN_WRITE: begin
				// A begin while a transaction runs is dropped.
				if (s.phase == PH_IDLE) begin
					s.addr = it.addr;
					s.rd_mode = (it.kind == KIND_BEGIN_READ);
					s.bytes_left = (s.rd_mode && it.len == 8'd0) ? 8'd1 : it.len;
					s.attempts_left = at_least_one(attempt_lim);
					s.hold_full = 1'b0;
					s.unit_cnt = 3'd0;
					s.bit_idx = 4'd0;
					s.polls = 16'd0;
					s.phase = PH_START;
				end
			end
			KIND_SUPPLY: begin
				if (bus_wants_byte(s)) begin
					s.hold_byte = it.wbyte;
					s.hold_full = 1'b1;
				end
			end
			KIND_TICK: begin
				case (s.phase)
					PH_START: begin
						s.drive = 1'b1;
						s.scl = 1'b1;
						s.sda = (s.unit_cnt == 3'd0);
						if (s.unit_cnt == 3'd0) begin
							s.unit_cnt = 3'd1;
						end else begin
							s.unit_cnt = 3'd0;
							s.bit_idx = 4'd0;
							s.shifter = s.addr;
							s.phase = PH_ADDR_TX;
						end
					end
					PH_ADDR_TX, PH_DATA_TX: shift_out_tick(s);
					PH_ADDR_ACK, PH_DATA_ACK: begin
						s.drive = 1'b0;
						s.scl = (s.unit_cnt >= 3'd2);
						if (s.unit_cnt < 3'd4) begin
							s.unit_cnt = s.unit_cnt + 3'd1;
							if (s.unit_cnt == 3'd4)
								s.polls = 16'd0;
						end else begin
							acked = !it.sda;
							if (!acked) begin
								s.polls = s.polls + 16'd1;
								still_polling = (s.polls < at_least_one(poll_lim));
							end
							if (!still_polling) begin
								s.unit_cnt = 3'd0;
								s.bit_idx = 4'd0;
								if (s.phase == PH_ADDR_ACK) begin
									if (acked && s.rd_mode) begin
										s.shifter = 8'd0;
										s.phase = PH_RX;
									end else if (acked) begin
										s.phase = (s.bytes_left != 8'd0) ? PH_LOAD : PH_PRESTOP;
									end else begin
										// Address refused: retry with a fresh start until the
										// attempts run out.
										s.attempts_left = s.attempts_left - 16'd1;
										if (s.attempts_left == 16'd0) begin
											s.phase = PH_IDLE;
											ended = 1'b1;
											code = STATUS_ADDR_NACK;
										end else begin
											s.phase = PH_START;
										end
									end
								end else if (acked) begin
									s.phase = (s.bytes_left != 8'd0) ? PH_LOAD : PH_PRESTOP;
								end else begin
									s.phase = PH_IDLE;
									ended = 1'b1;
									code = STATUS_DATA_NACK;
								end
							end
						end
					end
					PH_LOAD: begin
						// With the holder empty the engine simply waits here.
						s.drive = 1'b0;
						s.scl = 1'b0;
						if (s.hold_full) begin
							s.shifter = s.hold_byte;
							s.hold_full = 1'b0;
							s.bytes_left = s.bytes_left - 8'd1;
							s.bit_idx = 4'd0;
							s.unit_cnt = 3'd0;
							s.phase = PH_DATA_TX;
							shift_out_tick(s);
						end
					end
					PH_RX: begin
						s.drive = 1'b0;
						s.scl = (s.unit_cnt >= 3'd3);
						if (s.unit_cnt < 3'd4) begin
							s.unit_cnt = s.unit_cnt + 3'd1;
						end else begin
							s.unit_cnt = 3'd0;
							s.shifter = {s.shifter[6:0], it.sda};
							s.bit_idx = s.bit_idx + 4'd1;
							if (s.bit_idx >= 4'd8) begin
								s.bit_idx = 4'd0;
								r.read_valid = 1'b1;
								r.read_data = s.shifter;
								if (s.bytes_left != 8'd0)
									s.bytes_left = s.bytes_left - 8'd1;
								s.phase = PH_RX_ACK;
							end
						end
					end
					PH_RX_ACK: begin
						// The last byte is answered with a not-acknowledge.
						s.drive = 1'b1;
						s.scl = (s.unit_cnt >= 3'd2);
						if (s.unit_cnt == 3'd1)
							s.sda = (s.bytes_left == 8'd0);
						if (s.unit_cnt < 3'd3) begin
							s.unit_cnt = s.unit_cnt + 3'd1;
						end else begin
							s.unit_cnt = 3'd0;
							s.phase = (s.bytes_left != 8'd0) ? PH_RX : PH_STOP;
						end
					end
					PH_PRESTOP: begin
						s.drive = 1'b0;
						s.scl = 1'b0;
						if (s.unit_cnt < 3'd1) begin
							s.unit_cnt = s.unit_cnt + 3'd1;
						end else begin
							s.unit_cnt = 3'd0;
							s.phase = PH_STOP;
						end
					end
					PH_STOP: begin
						s.drive = 1'b1;
						s.scl = 1'b1;
						s.sda = (s.unit_cnt != 3'd0);
						if (s.unit_cnt == 3'd0) begin
							s.unit_cnt = 3'd1;
						end else begin
							s.unit_cnt = 3'd0;
							s.phase = PH_IDLE;
							ended = 1'b1;
							code = STATUS_OK;
						end
					end
					PH_IDLE: ;
					default: begin
						s.phase = PH_IDLE;
						s.unit_cnt = 3'd0;
					end
				endcase
			end
		endcase
		r.scl_level = s.scl;
		r.sda_level = s.sda;
		r.sda_driven = s.drive;
		r.byte_request = bus_wants_byte(s);
		r.busy_res = (s.phase != PH_IDLE);
		r.done_res = ended;
		r.status = ended ? code : STATUS_OK;
		// A failed transaction leaves SCL low and SDA released, after the done tick.
		if (ended && code != STATUS_OK) begin
			s.scl = 1'b0;
			s.drive = 1'b0;
		end
		return r;
	endfunction

	// ------------------------------------------------------------------------------------
	// Stimulus planning. The planner steps its own copy of the engine so that it knows the
	// bus phase and can answer acknowledge polls and byte requests sensibly.
	// ------------------------------------------------------------------------------------

	function automatic bus_item_t random_item(input logic [1:0] k);
		bus_item_t it;
		it.kind = k;
		it.addr = 8'($urandom_range(0, 255));
		it.len = 8'($urandom_range(0, 255));
		it.wbyte = 8'($urandom_range(0, 255));
		it.sda = 1'($urandom_range(0, 1));
		return it;
	endfunction

	task automatic plan_item(input bus_item_t it);
		void'(advance_bus_engine(planned_bus, it, ack_poll_limit_cfg, attempt_limit_cfg));
		pending_bus_items.push_back(it);
		planned_count++;
	endtask

	task automatic plan_begin(input logic [1:0] k, input logic [7:0] addr, input logic [7:0] len);
		bus_item_t it;
		it = random_item(k);
		it.addr = addr;
		it.len = len;
		plan_item(it);
	endtask

	// Feeds ticks until the running transaction ends. The acknowledge percentages give the
	// chance that a poll sample reads SDA low. With lazy supply set, write bytes arrive only
	// once the engine is already waiting on an empty holder.
	task automatic finish_transfer(input int addr_ack_pct, input int data_ack_pct,
			input int noise_pct, input logic lazy_supply);
		bus_item_t it;
		logic      supply_now;
		while (planned_bus.phase != PH_IDLE) begin
			if (lazy_supply)
				supply_now = planned_bus.phase == PH_LOAD && $urandom_range(0, 99) < 30;
			else
				supply_now = $urandom_range(0, 99) < 10;
			if ($urandom_range(0, 99) < noise_pct) begin
				// Begins are ignored while busy; a supply may or may not be wanted.
				it = random_item(2'($urandom_range(1, 3)));
			end else if (bus_wants_byte(planned_bus) && supply_now) begin
				it = random_item(KIND_SUPPLY);
			end else begin
				it = random_item(KIND_TICK);
				if (planned_bus.phase == PH_ADDR_ACK && planned_bus.unit_cnt == 3'd4)
					it.sda = ($urandom_range(0, 99) >= addr_ack_pct);
				else if (planned_bus.phase == PH_DATA_ACK && planned_bus.unit_cnt == 3'd4)
					it.sda = ($urandom_range(0, 99) >= data_ack_pct);
			end
			plan_item(it);
		end
	endtask

	task automatic run_transfer(input logic [1:0] k, input logic [7:0] addr, input logic [7:0] len,
			input int addr_ack_pct, input int data_ack_pct, input logic lazy_supply);
		plan_begin(k, addr, len);
		finish_transfer(addr_ack_pct, data_ack_pct, 0, lazy_supply);
	endtask

	// Random traffic: mostly complete transactions of short length, with stray items while
	// idle and a sprinkling of noise inside each transaction.
	task automatic run_random(input int budget, input int addr_ack_pct, input int data_ack_pct);
		int stop_at;
		stop_at = planned_count + budget;
		while (planned_count < stop_at) begin
			repeat ($urandom_range(0, 2))
				plan_item(random_item($urandom_range(0, 1) ? KIND_TICK : KIND_SUPPLY));
			plan_begin($urandom_range(0, 1) ? KIND_BEGIN_READ : KIND_BEGIN_WRITE,
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 4)));
			finish_transfer(addr_ack_pct, data_ack_pct, 6, $urandom_range(0, 2) == 0);
		end
	endtask

	// Waits until every planned transaction went in and every predicted result came out.
	// The check runs at the falling edge, once the driver and monitor have settled.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_bus_items.size() != 0 || in_valid || predicted_bus_q.size() != 0
			|| out_valid);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_ACK_POLL_LIMIT)
			ack_poll_limit_cfg = value;
		else if (idx == CFG_ADDR_ATTEMPT_LIM)
			attempt_limit_cfg = value;
	endtask

	task automatic set_limits(input logic [15:0] polls, input logic [15:0] attempts);
		wait_drained();
		write_register(CFG_ACK_POLL_LIMIT, polls);
		write_register(CFG_ADDR_ATTEMPT_LIM, attempts);
	endtask

	// ------------------------------------------------------------------------------------
	// Driver: presents the next pending item whenever the current one has been taken, or
	// nothing is on the channel. An item on a stalled channel is held unchanged.
	// ------------------------------------------------------------------------------------

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (pending_bus_items.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
				kind <= pending_bus_items[0].kind;
				address_byte <= pending_bus_items[0].addr;
				transfer_length <= pending_bus_items[0].len;
				write_byte <= pending_bus_items[0].wbyte;
				sda_sample <= pending_bus_items[0].sda;
				in_valid <= 1'b1;
				void'(pending_bus_items.pop_front());
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// The result side stalls at random with the same rate as the input side idles.
	always @(posedge clk) begin
		if (!arst_n)
			out_stall <= 1'b0;
		else
			out_stall <= ($urandom_range(0, 99) < gap_pct);
	end

	// ------------------------------------------------------------------------------------
	// Monitor: each accepted result is matched against the oldest prediction, and each
	// accepted input advances the checker's copy of the engine.
	// ------------------------------------------------------------------------------------

	task automatic check_field(input string field_name, input logic [7:0] want,
			input logic [7:0] seen);
		if (seen !== want) begin
			fault_count++;
			if (fault_count <= REPORT_LIMIT)
				$display("result %0d: %s expected 0x%02h, got 0x%02h",
					results_seen, field_name, want, seen);
		end
	endtask

	always @(posedge clk) begin
		result_t   want;
		result_t   seen;
		bus_item_t taken;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				seen = {scl_level, sda_level, sda_driven, byte_request, read_valid, read_data,
					busy_res, done_res, status};
				if (predicted_bus_q.size() == 0) begin
					fault_count++;
					if (fault_count <= REPORT_LIMIT)
						$display("result %0d arrived with nothing predicted: 0x%04h",
							results_seen, seen);
				end else begin
					want = predicted_bus_q.pop_front();
					check_field("scl_level", 8'(want.scl_level), 8'(seen.scl_level));
					check_field("sda_level", 8'(want.sda_level), 8'(seen.sda_level));
					check_field("sda_driven", 8'(want.sda_driven), 8'(seen.sda_driven));
					check_field("byte_request", 8'(want.byte_request), 8'(seen.byte_request));
					check_field("read_valid", 8'(want.read_valid), 8'(seen.read_valid));
					check_field("read_data", want.read_data, seen.read_data);
					check_field("busy_res", 8'(want.busy_res), 8'(seen.busy_res));
					check_field("done_res", 8'(want.done_res), 8'(seen.done_res));
					check_field("status", 8'(want.status), 8'(seen.status));
				end
				results_seen++;
			end
			if (in_valid && !in_stall) begin
				taken = {kind, address_byte, transfer_length, write_byte, sda_sample};
				predicted_bus_q.push_back(advance_bus_engine(accepted_bus, taken,
					ack_poll_limit_cfg, attempt_limit_cfg));
			end
		end
	end

	// ------------------------------------------------------------------------------------
	// Watchdog: counts cycles in which no channel completes a transaction.
	// ------------------------------------------------------------------------------------

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT && !verdict_given);
		$display("TEST FAILED");
		$finish;
	end

	// ------------------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------------------

	initial begin
		bus_item_t it;
		planned_bus = bus_after_reset();
		accepted_bus = bus_after_reset();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset limits. A supply and a tick while idle are both
		// harmless; they still produce a result carrying the idle bus levels.
		it = random_item(KIND_SUPPLY);
		it.wbyte = 8'hA5;
		plan_item(it);
		it = random_item(KIND_TICK);
		it.sda = 1'b0;
		plan_item(it);

		// Write of zero bytes: address, acknowledge, then straight to stop. A begin that
		// arrives mid-transaction must be ignored.
		plan_begin(KIND_BEGIN_WRITE, 8'hFF, 8'd0);
		plan_begin(KIND_BEGIN_READ, 8'h00, 8'd255);
		finish_transfer(100, 100, 0, 1'b0);

		// Read of zero bytes moves exactly one byte.
		run_transfer(KIND_BEGIN_READ, 8'h00, 8'd0, 100, 100, 1'b0);

		// Two-byte write: the first byte is loaded early with all ones, the second arrives
		// only after the engine has been left waiting on an empty holder.
		plan_begin(KIND_BEGIN_WRITE, 8'h5A, 8'd2);
		it = random_item(KIND_SUPPLY);
		it.wbyte = 8'hFF;
		plan_item(it);
		finish_transfer(100, 100, 0, 1'b1);

		// Smallest limits: one poll, one attempt. Address and data refusals end without a
		// stop, and the long length never matters because the transfer fails first.
		set_limits(16'd1, 16'd1);
		run_transfer(KIND_BEGIN_WRITE, 8'hA4, 8'd1, 0, 0, 1'b0);
		run_transfer(KIND_BEGIN_WRITE, 8'hC3, 8'd255, 100, 0, 1'b0);

		// Limits written as zero behave as one.
		set_limits(16'd0, 16'd0);
		run_transfer(KIND_BEGIN_READ, 8'h81, 8'd2, 0, 0, 1'b0);

		// Largest limits, and a long stretch without any idling or stalls.
		set_limits(16'hFFFF, 16'hFFFF);
		gap_pct = 0;
		run_random(80, 40, 50);

		// Tight limits with frequent refusals, so retries and both failure ends show up.
		set_limits(16'd3, 16'd2);
		gap_pct = 15;
		run_random(60, 25, 40);

		wait_drained();
		repeat (8) @(posedge clk);
		verdict_given = 1'b1;
		if (fault_count == 0 && predicted_bus_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
